// ===== sv/wbr_pkg.sv =====
// Shared types, codes and constants of the windowed block receiver.
package wbr_pkg;

  // Default sizes
  localparam int unsigned BUFFER_BLOCKS_DEF  = 16;
  localparam int unsigned RETRANSMIT_MAX_DEF = 16;
  // Hard cap on retransmit entries sent at one window end
  localparam int unsigned RTX_CAP            = 18;

  // Input mode codes (all other codes are unknown opcodes)
  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_DATA  = 3'd1;
  localparam logic [2:0] MODE_ERROR = 3'd2;
  localparam logic [2:0] MODE_TICK  = 3'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_WINDOW_BLOCKS    = 3'd0;
  localparam logic [2:0] CFG_START_OFFSET     = 3'd1;
  localparam logic [2:0] CFG_FILE_NUMBER      = 3'd2;
  localparam logic [2:0] CFG_FULL_BLOCK_BYTES = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT_TICKS    = 3'd4;

  // Configuration reset values
  localparam logic [7:0]  FULL_BYTES_RST = 8'd128;
  localparam logic [31:0] TIMEOUT_RST    = 32'd1000;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_XFER  = 2'd1,
    PH_RTX   = 2'd2,
    PH_ACKED = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    ACT_REQUEST = 4'd0,
    ACT_WRITE   = 4'd1,
    ACT_STORE   = 4'd2,
    ACT_FLUSH   = 4'd3,
    ACT_ACK     = 4'd4,
    ACT_RTX     = 4'd5,
    ACT_STATUS  = 4'd6,
    ACT_TIMEOUT = 4'd7,
    ACT_END     = 4'd8
  } act_e;

  typedef enum logic [2:0] {
    RS_OK         = 3'd0,
    RS_AFTER_ACK  = 3'd1,
    RS_BAD_BLOCK  = 3'd2,
    RS_BAD_LENGTH = 3'd3,
    RS_BAD_OPCODE = 3'd4
  } rstat_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DCHK,
    ST_DORD,
    ST_DSTORE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_STORE,
    ST_APPEND,
    ST_WCHK,
    ST_FMUL,
    ST_FADD,
    ST_WEND,
    ST_WEND_END,
    ST_RTX_RD,
    ST_RTX_CMP,
    ST_FINISH,
    ST_DRAIN
  } ctl_state_e;

  // One result item without the per-input trailer fields
  typedef struct packed {
    act_e        action;
    logic [31:0] byte_offset;
    logic [15:0] byte_count;
    logic [3:0]  buffer_slot;
    logic [15:0] block_field;
  } res_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic   load;
    logic   start;
    logic   win_start;
    logic   set_st;
    rstat_e st;
    logic   set_ph;
    phase_e ph;
    logic   set_good;
    logic   clr_good;
    logic   upd_largest;
    logic   direct;
    logic   set_base;
    logic   scan_clr;
    logic   scan_inc;
    logic   remove;
    logic   append_init;
    logic   append_step;
    logic   set_lb;
    logic   flush_mul;
    logic   flush_add;
    logic   tick;
    logic   push;
    act_e   push_act;
    logic   finish;
    logic   pop;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [2:0] mode;
    logic       lok;
    phase_e     phase;
    logic       blk_nz;
    logic       blk_ge_wb;
    logic       seq_next;
    logic       mt_zero;
    logic       base_neg;
    logic       dist_ok;
    logic       hit;
    logic       slot_valid;
    logic       scan_end;
    logic       mt_full;
    logic       app_more;
    logic       len_short;
    logic       win_last;
    logic       large_short;
    logic       tick_hit;
    logic       rtx_room;
    logic       q_empty;
    logic       drain_last;
    logic       out_free;
  } sts_t;

endpackage

// ===== sv/wbr_in_if.sv =====
// Input item channel: valid, ready and the packet fields.
interface wbr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic        length_ok;
  logic [15:0] block_number;
  logic [7:0]  payload_bytes;

  modport source (output valid, mode, length_ok, block_number, payload_bytes, input ready);
  modport sink   (input valid, mode, length_ok, block_number, payload_bytes, output ready);
endinterface

// ===== sv/wbr_out_if.sv =====
// Result item channel: valid, ready and the result fields.
interface wbr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [31:0] byte_offset;
  logic [15:0] byte_count;
  logic [3:0]  buffer_slot;
  logic [15:0] block_field;
  logic [4:0]  missing_count;
  logic [2:0]  receive_status;
  logic [1:0]  state_after;
  logic        last;

  modport source (output valid, action, byte_offset, byte_count, buffer_slot, block_field,
                  missing_count, receive_status, state_after, last, input ready);
  modport sink   (input valid, action, byte_offset, byte_count, buffer_slot, block_field,
                  missing_count, receive_status, state_after, last, output ready);
endinterface

// ===== sv/wbr_ctrl.sv =====
// Sequencing state machine of the windowed block receiver.
module wbr_ctrl
  import wbr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctl_state_e state_q, state_d;
  logic       inorder;

  assign inorder = (sts_i.phase != PH_RTX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (sts_i.mode == MODE_DATA && sts_i.lok && sts_i.phase != PH_IDLE &&
            !(sts_i.phase == PH_ACKED && sts_i.blk_nz)) begin
          state_d = ST_DCHK;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DCHK: state_d = sts_i.blk_ge_wb ? ST_FINISH : ST_DORD;
      ST_DORD: state_d = (inorder && sts_i.mt_zero && sts_i.seq_next) ? ST_WCHK : ST_DSTORE;
      ST_DSTORE: begin
        if (!sts_i.base_neg && sts_i.dist_ok) begin
          state_d = inorder ? ST_STORE : ST_SRCH_RD;
        end else begin
          state_d = ST_WCHK;
        end
      end
      ST_SRCH_RD: state_d = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if (sts_i.hit) state_d = ST_STORE;
        else if (sts_i.scan_end) state_d = ST_FINISH;
        else state_d = ST_SRCH_RD;
      end
      ST_STORE: state_d = inorder ? ST_APPEND : ST_WCHK;
      ST_APPEND: state_d = (sts_i.app_more && !sts_i.mt_full) ? ST_APPEND : ST_WCHK;
      ST_WCHK: begin
        if (inorder) begin
          state_d = (sts_i.len_short || sts_i.win_last) ? ST_WEND : ST_FINISH;
        end else begin
          state_d = sts_i.mt_zero ? ST_FMUL : ST_FINISH;
        end
      end
      ST_FMUL: state_d = ST_FADD;
      ST_FADD: state_d = ST_WEND;
      ST_WEND: begin
        if (!sts_i.mt_zero) state_d = ST_RTX_RD;
        else state_d = sts_i.large_short ? ST_WEND_END : ST_FINISH;
      end
      ST_WEND_END: state_d = ST_FINISH;
      ST_RTX_RD: state_d = ST_RTX_CMP;
      ST_RTX_CMP: state_d = sts_i.scan_end ? ST_FINISH : ST_RTX_RD;
      ST_FINISH: state_d = ST_DRAIN;
      ST_DRAIN: if (sts_i.out_free && sts_i.drain_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC: begin
        case (sts_i.mode)
          MODE_START: begin
            if (sts_i.phase == PH_IDLE) begin
              cmd_o.start    = 1'b1;
              cmd_o.push     = 1'b1;
              cmd_o.push_act = ACT_REQUEST;
              cmd_o.set_ph   = 1'b1;
              cmd_o.ph       = PH_XFER;
            end
          end
          MODE_DATA: begin
            if (!sts_i.lok) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = RS_BAD_LENGTH;
            end else if (sts_i.phase == PH_ACKED) begin
              if (sts_i.blk_nz) begin
                cmd_o.set_st = 1'b1;
                cmd_o.st     = RS_AFTER_ACK;
                cmd_o.set_ph = 1'b1;
                cmd_o.ph     = PH_IDLE;
              end else begin
                cmd_o.win_start = 1'b1;
                cmd_o.set_ph    = 1'b1;
                cmd_o.ph        = PH_XFER;
              end
            end
          end
          MODE_ERROR: begin
            if (!sts_i.lok) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = RS_BAD_LENGTH;
            end else begin
              cmd_o.set_good = 1'b1;
              cmd_o.set_ph   = 1'b1;
              cmd_o.ph       = PH_IDLE;
            end
          end
          MODE_TICK: begin
            if (sts_i.phase != PH_IDLE) begin
              cmd_o.tick = 1'b1;
              if (sts_i.tick_hit) begin
                cmd_o.push     = 1'b1;
                cmd_o.push_act = ACT_TIMEOUT;
                cmd_o.set_ph   = 1'b1;
                cmd_o.ph       = PH_IDLE;
              end
            end
          end
          default: begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = RS_BAD_OPCODE;
          end
        endcase
      end
      ST_DCHK: begin
        if (sts_i.blk_ge_wb) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = RS_BAD_BLOCK;
          cmd_o.set_ph = 1'b1;
          cmd_o.ph     = PH_IDLE;
        end else begin
          cmd_o.set_good    = 1'b1;
          cmd_o.upd_largest = 1'b1;
        end
      end
      ST_DORD: begin
        if (inorder && sts_i.mt_zero) begin
          if (sts_i.seq_next) begin
            cmd_o.direct   = 1'b1;
            cmd_o.push     = 1'b1;
            cmd_o.push_act = ACT_WRITE;
          end else if (sts_i.base_neg) begin
            cmd_o.set_base = 1'b1;
          end
        end
      end
      ST_DSTORE: cmd_o.scan_clr = !sts_i.base_neg && sts_i.dist_ok && !inorder;
      ST_SRCH_CMP: begin
        if (sts_i.hit) begin
          cmd_o.remove = 1'b1;
        end else if (sts_i.scan_end) begin
          cmd_o.set_st   = 1'b1;
          cmd_o.st       = RS_BAD_BLOCK;
          cmd_o.clr_good = 1'b1;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      ST_STORE: begin
        cmd_o.push        = 1'b1;
        cmd_o.push_act    = ACT_STORE;
        cmd_o.append_init = inorder;
      end
      ST_APPEND: begin
        if (sts_i.app_more && !sts_i.mt_full) cmd_o.append_step = 1'b1;
        else cmd_o.set_lb = 1'b1;
      end
      ST_FMUL: cmd_o.flush_mul = 1'b1;
      ST_FADD: begin
        cmd_o.flush_add = 1'b1;
        cmd_o.push      = 1'b1;
        cmd_o.push_act  = ACT_FLUSH;
      end
      ST_WEND: begin
        cmd_o.set_ph = 1'b1;
        if (!sts_i.mt_zero) begin
          cmd_o.ph       = PH_RTX;
          cmd_o.scan_clr = 1'b1;
        end else begin
          cmd_o.push     = 1'b1;
          cmd_o.push_act = ACT_ACK;
          cmd_o.ph       = sts_i.large_short ? PH_IDLE : PH_ACKED;
        end
      end
      ST_WEND_END: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_act = ACT_END;
      end
      ST_RTX_CMP: begin
        if (sts_i.slot_valid && sts_i.rtx_room) begin
          cmd_o.push     = 1'b1;
          cmd_o.push_act = ACT_RTX;
        end
        cmd_o.scan_inc = !sts_i.scan_end;
      end
      ST_FINISH: begin
        cmd_o.finish   = 1'b1;
        cmd_o.push     = sts_i.q_empty;
        cmd_o.push_act = ACT_STATUS;
      end
      ST_DRAIN: cmd_o.pop = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== sv/wbr_datapath.sv =====
// Datapath: configuration, window state, missing list memory, result queue, output register.
module wbr_datapath
  import wbr_pkg::*;
#(
  parameter int unsigned BUFFER_BLOCKS  = BUFFER_BLOCKS_DEF,
  parameter int unsigned RETRANSMIT_MAX = RETRANSMIT_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [2:0]  mode_i,
  input  logic        length_ok_i,
  input  logic [15:0] block_number_i,
  input  logic [7:0]  payload_bytes_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [3:0]  action_o,
  output logic [31:0] byte_offset_o,
  output logic [15:0] byte_count_o,
  output logic [3:0]  buffer_slot_o,
  output logic [15:0] block_field_o,
  output logic [4:0]  missing_count_o,
  output logic [2:0]  receive_status_o,
  output logic [1:0]  state_after_o,
  output logic        last_o
);

  localparam int unsigned IW   = $clog2(BUFFER_BLOCKS);
  localparam int unsigned MTW  = $clog2(BUFFER_BLOCKS + 1);
  localparam int unsigned LIM  = (RETRANSMIT_MAX < RTX_CAP) ? RETRANSMIT_MAX : RTX_CAP;
  localparam int unsigned ECW  = $clog2(LIM + 1);
  localparam int unsigned QD   = (LIM + 1 > 4) ? LIM + 1 : 4;
  localparam int unsigned QIW  = $clog2(QD);
  localparam int unsigned QCW  = $clog2(QD + 1);

  // Configuration
  logic [7:0]  wb_q, fbb_q;
  logic [31:0] so_q, to_q;
  logic [15:0] fn_q;

  // Captured item
  logic [2:0]  mode_q;
  logic        lok_q;
  logic [15:0] blk_q;
  logic [7:0]  len_q;

  // Window state
  phase_e             phase_q, np_q;
  rstat_e             st_q;
  logic               good_q;
  logic signed [16:0] lb_q, lgb_q, bb_q, m_q;
  logic [7:0]         ll_q;
  logic [MTW-1:0]     mt_q;
  logic [31:0]        ro_q, it_q;
  logic [BUFFER_BLOCKS-1:0] valid_q;
  logic [IW-1:0]      idx_q;
  logic [ECW-1:0]     ecnt_q;
  logic [15:0]        rd_q, prod_q;

  // Missing list and result queue
  logic [15:0] miss_mem [BUFFER_BLOCKS];
  res_t        q_mem [QD];
  logic [QCW-1:0] n_q;
  logic [QIW-1:0] rp_q;

  // Output register
  logic        out_valid_q, out_last_q;
  res_t        out_res_q;
  logic [4:0]  out_mc_q;
  rstat_e      out_st_q;
  phase_e      out_ph_q;

  // Derived values
  logic signed [17:0] b18, lb18, bb18, m18, bdist;
  logic [31:0] it_inc;
  logic [15:0] flush_cnt, diff16;
  logic [23:0] prod_full;
  res_t        res_new;

  assign b18    = signed'({2'b00, blk_q});
  assign lb18   = 18'(lb_q);
  assign bb18   = 18'(bb_q);
  assign m18    = 18'(m_q);
  assign bdist  = b18 - bb18;
  assign it_inc = (it_q == 32'hFFFF_FFFF) ? it_q : it_q + 32'd1;
  assign diff16 = lgb_q[15:0] - bb_q[15:0];
  assign prod_full = diff16 * fbb_q;
  assign flush_cnt = prod_q + {8'd0, ll_q};

  always_comb begin
    sts_o.mode        = mode_q;
    sts_o.lok         = lok_q;
    sts_o.phase       = phase_q;
    sts_o.blk_nz      = (blk_q != 16'd0);
    sts_o.blk_ge_wb   = (blk_q >= {8'd0, wb_q});
    sts_o.seq_next    = (b18 == lb18 + 18'sd1);
    sts_o.mt_zero     = (mt_q == '0);
    sts_o.base_neg    = bb_q[16];
    sts_o.dist_ok     = !bdist[17] && ({1'b0, bdist[16:0]} < 18'(BUFFER_BLOCKS));
    sts_o.hit         = valid_q[idx_q] && (rd_q == blk_q);
    sts_o.slot_valid  = valid_q[idx_q];
    sts_o.scan_end    = (idx_q == IW'(BUFFER_BLOCKS - 1));
    sts_o.mt_full     = (mt_q == MTW'(BUFFER_BLOCKS));
    sts_o.app_more    = (m18 < b18);
    sts_o.len_short   = (len_q < fbb_q);
    sts_o.win_last    = ({1'b0, blk_q} + 17'd1 == {9'd0, wb_q});
    sts_o.large_short = (ll_q < fbb_q);
    sts_o.tick_hit    = (it_inc >= to_q);
    sts_o.rtx_room    = (ecnt_q < ECW'(LIM));
    sts_o.q_empty     = (n_q == '0);
    sts_o.drain_last  = (QCW'(rp_q) == n_q - QCW'(1));
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  // Result builder
  always_comb begin
    res_new        = '0;
    res_new.action = cmd_i.push_act;
    case (cmd_i.push_act)
      ACT_REQUEST: begin
        res_new.byte_offset = so_q;
        res_new.byte_count  = {8'd0, wb_q};
        res_new.block_field = fn_q;
      end
      ACT_WRITE: begin
        res_new.byte_offset = ro_q;
        res_new.byte_count  = {8'd0, len_q};
      end
      ACT_STORE: begin
        res_new.byte_count  = {8'd0, len_q};
        res_new.buffer_slot = bdist[3:0];
      end
      ACT_FLUSH: begin
        res_new.byte_offset = ro_q;
        res_new.byte_count  = flush_cnt;
      end
      ACT_ACK: res_new.block_field = lb_q[15:0];
      ACT_RTX: res_new.block_field = rd_q;
      default: res_new.block_field = 16'd0;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q        <= 8'd0;
      so_q        <= 32'd0;
      fn_q        <= 16'd0;
      fbb_q       <= FULL_BYTES_RST;
      to_q        <= TIMEOUT_RST;
      phase_q     <= PH_IDLE;
      np_q        <= PH_IDLE;
      st_q        <= RS_OK;
      good_q      <= 1'b0;
      lb_q        <= '1;
      lgb_q       <= '1;
      bb_q        <= '1;
      m_q         <= '0;
      ll_q        <= 8'd0;
      mt_q        <= '0;
      ro_q        <= 32'd0;
      it_q        <= 32'd0;
      valid_q     <= '0;
      idx_q       <= '0;
      ecnt_q      <= '0;
      n_q         <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_BLOCKS:    wb_q  <= cfg_data_i[7:0];
          CFG_START_OFFSET:     so_q  <= cfg_data_i;
          CFG_FILE_NUMBER:      fn_q  <= cfg_data_i[15:0];
          CFG_FULL_BLOCK_BYTES: fbb_q <= cfg_data_i[7:0];
          CFG_TIMEOUT_TICKS:    to_q  <= cfg_data_i;
          default: ;
        endcase
      end
      // Per-item bookkeeping
      if (cmd_i.load) begin
        st_q   <= RS_OK;
        good_q <= 1'b0;
        np_q   <= phase_q;
        n_q    <= '0;
        rp_q   <= '0;
      end
      if (cmd_i.set_st) st_q <= cmd_i.st;
      if (cmd_i.set_ph) np_q <= cmd_i.ph;
      if (cmd_i.set_good) good_q <= 1'b1;
      if (cmd_i.clr_good) good_q <= 1'b0;
      // New window
      if (cmd_i.start || cmd_i.win_start) begin
        lb_q    <= '1;
        lgb_q   <= '1;
        bb_q    <= '1;
        ll_q    <= 8'd0;
        mt_q    <= '0;
        valid_q <= '0;
      end
      if (cmd_i.start) begin
        ro_q <= so_q;
        it_q <= 32'd0;
      end
      if (cmd_i.upd_largest && (b18 > 18'(lgb_q))) begin
        lgb_q <= b18[16:0];
        ll_q  <= len_q;
      end
      // In-order delivery
      if (cmd_i.direct) begin
        lb_q <= b18[16:0];
        ro_q <= ro_q + {24'd0, len_q};
      end
      if (cmd_i.set_base) bb_q <= 17'(lb18 + 18'sd1);
      // Missing list scan
      if (cmd_i.scan_clr) begin
        idx_q  <= '0;
        ecnt_q <= '0;
      end
      if (cmd_i.scan_inc) idx_q <= idx_q + IW'(1);
      if (cmd_i.remove) begin
        valid_q[idx_q] <= 1'b0;
        if (mt_q != '0) mt_q <= mt_q - MTW'(1);
      end
      // Skipped block recording
      if (cmd_i.append_init) m_q <= 17'(lb18 + 18'sd1);
      if (cmd_i.append_step) begin
        valid_q[mt_q[IW-1:0]] <= 1'b1;
        mt_q <= mt_q + MTW'(1);
        m_q  <= m_q + 17'sd1;
      end
      if (cmd_i.set_lb) lb_q <= b18[16:0];
      if (cmd_i.flush_add) ro_q <= ro_q + {16'd0, flush_cnt};
      if (cmd_i.tick) it_q <= it_inc;
      // Result queue
      if (cmd_i.push) begin
        n_q <= n_q + QCW'(1);
        if (cmd_i.push_act == ACT_RTX) ecnt_q <= ecnt_q + ECW'(1);
      end
      // Close the item
      if (cmd_i.finish) begin
        phase_q <= np_q;
        if (good_q || np_q == PH_IDLE) it_q <= 32'd0;
      end
      // Output register
      if (cmd_i.pop) begin
        out_valid_q <= 1'b1;
        rp_q        <= rp_q + QIW'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      lok_q  <= length_ok_i;
      blk_q  <= block_number_i;
      len_q  <= payload_bytes_i;
    end
    if (cmd_i.append_step) miss_mem[mt_q[IW-1:0]] <= m_q[15:0];
    rd_q <= miss_mem[idx_q];
    if (cmd_i.flush_mul) prod_q <= prod_full[15:0];
    if (cmd_i.push) q_mem[n_q[QIW-1:0]] <= res_new;
    if (cmd_i.pop) begin
      out_res_q  <= q_mem[rp_q];
      out_last_q <= sts_o.drain_last;
      out_mc_q   <= 5'(mt_q);
      out_st_q   <= st_q;
      out_ph_q   <= phase_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign action_o         = out_res_q.action;
  assign byte_offset_o    = out_res_q.byte_offset;
  assign byte_count_o     = out_res_q.byte_count;
  assign buffer_slot_o    = out_res_q.buffer_slot;
  assign block_field_o    = out_res_q.block_field;
  assign missing_count_o  = out_mc_q;
  assign receive_status_o = out_st_q;
  assign state_after_o    = out_ph_q;
  assign last_o           = out_last_q;

endmodule

// ===== sv/windowed_block_receiver.sv =====
// Top level of the windowed block receiver: controller and datapath.
// Usage:
//  in_i carries one packet event per item (start, data, error, tick, other);
//  out_o returns one or more result items per input item, the final one
//  flagged by last. Configuration is written through cfg_we_i/cfg_idx_i/
//  cfg_data_i while no item is in progress.
// Sequencing:
//  one item at a time. A data item records each skipped block (at most
//  BUFFER_BLOCKS) and walks the missing list entry by entry for each
//  missing-list scan (retransmit match or retransmit list emission), the
//  scan being paced by the single read port of the missing-list memory.
//  Results then leave at one per cycle while out_o.ready is high; in_i.ready
//  rises the cycle after the last result is loaded into the output register.
// Reset: window state is cleared, phase is idle, registers take their
//  reset values; the missing list needs no clearing pass (valid bits).
// Stalls: a held-off result stays in the output register; a new item is
//  taken while the final result of the previous one still waits.
module windowed_block_receiver
  import wbr_pkg::*;
#(
  parameter int unsigned BUFFER_BLOCKS  = BUFFER_BLOCKS_DEF,
  parameter int unsigned RETRANSMIT_MAX = RETRANSMIT_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  wbr_in_if.sink      in_i,
  wbr_out_if.source   out_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_i.ready = in_ready;

  wbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wbr_datapath #(
    .BUFFER_BLOCKS  (BUFFER_BLOCKS),
    .RETRANSMIT_MAX (RETRANSMIT_MAX)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mode_i           (in_i.mode),
    .length_ok_i      (in_i.length_ok),
    .block_number_i   (in_i.block_number),
    .payload_bytes_i  (in_i.payload_bytes),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .action_o         (out_o.action),
    .byte_offset_o    (out_o.byte_offset),
    .byte_count_o     (out_o.byte_count),
    .buffer_slot_o    (out_o.buffer_slot),
    .block_field_o    (out_o.block_field),
    .missing_count_o  (out_o.missing_count),
    .receive_status_o (out_o.receive_status),
    .state_after_o    (out_o.state_after),
    .last_o           (out_o.last)
  );

endmodule

// ===== sv/wbr_checker.sv =====
// Port-level checks of the windowed block receiver and their bind.
module wbr_checker
  import wbr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  action_i,
  input logic [31:0] byte_offset_i,
  input logic [15:0] block_field_i,
  input logic [1:0]  state_after_i,
  input logic        last_i
);

  // An accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken twice in a row");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(action_i) &&
    $stable(byte_offset_i) && $stable(block_field_i) && $stable(last_i))
    else $error("stalled result changed");

  // No new item while results of the current one are still to come
  a_no_input_mid_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |-> !in_ready_i)
    else $error("input ready before final result");

  // A timeout is the only result of its item and leaves the block idle
  a_timeout_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && action_i == 4'(ACT_TIMEOUT) |-> last_i && state_after_i == 2'(PH_IDLE))
    else $error("timeout result not final or not idle");

endmodule

bind windowed_block_receiver wbr_checker u_wbr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .action_i      (out_o.action),
  .byte_offset_i (out_o.byte_offset),
  .block_field_i (out_o.block_field),
  .state_after_i (out_o.state_after),
  .last_i        (out_o.last)
);

// ===== dv/windowed_block_receiver_tb.sv =====
// Self-checking testbench of the windowed block receiver: directed and random packet streams.
module windowed_block_receiver_tb;
  import wbr_pkg::*;

  localparam int unsigned NBUF   = 16;
  localparam int unsigned RTXLIM = 16;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [2:0]  mode;
    logic        lok;
    logic [15:0] blk;
    logic [7:0]  len;
  } pkt_t;

  typedef struct packed {
    act_e        action;
    logic [31:0] off;
    logic [15:0] cnt;
    logic [3:0]  slot;
    logic [15:0] blk;
    logic [4:0]  mc;
    rstat_e      st;
    phase_e      ph;
    logic        last;
  } rcpt_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  wbr_in_if  in_if ();
  wbr_out_if out_if ();

  windowed_block_receiver uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Stimulus, expectations and bookkeeping
  pkt_t  pkt_q[$];
  rcpt_t due_results_q[$];
  rcpt_t step_q[$];
  int    errors;
  int    snd_idle;
  int    rcv_idle;
  logic  in_taken;

  // Copy of the configuration
  logic [7:0]  win_blocks;
  logic [31:0] start_off;
  logic [15:0] file_no;
  logic [7:0]  full_bytes;
  logic [31:0] tmo_ticks;

  // Copy of the receiver state
  phase_e      ph;
  int          last_blk;
  int          top_blk;
  int          buf_base;
  int          top_len;
  int          miss_total;
  logic [15:0] miss_list [NBUF];
  logic        miss_vld  [NBUF];
  logic [31:0] run_off;
  logic [31:0] idle_cnt;

  // Per-item scratch of the predictor
  rstat_e      cur_st;
  phase_e      next_ph;
  logic        good_pkt;

  task automatic add_result(act_e a, logic [31:0] o, logic [15:0] c, logic [3:0] s,
                            logic [15:0] b);
    rcpt_t r;
    r = '0;
    r.action = a;
    r.off    = o;
    r.cnt    = c;
    r.slot   = s;
    r.blk    = b;
    step_q.push_back(r);
  endtask

  task automatic clear_window();
    last_blk   = -1;
    top_blk    = -1;
    top_len    = 0;
    buf_base   = -1;
    miss_total = 0;
    for (int i = 0; i < NBUF; i++) begin
      miss_list[i] = 16'hFFFF;
      miss_vld[i]  = 1'b0;
    end
  endtask

  // End of window: retransmit list, or ack and possibly end of transfer
  task automatic close_window();
    int n;
    n = 0;
    if (miss_total > 0) begin
      for (int i = 0; i < NBUF; i++) begin
        if (miss_vld[i] && n < RTXLIM) begin
          add_result(ACT_RTX, '0, '0, '0, miss_list[i]);
          n++;
        end
      end
      next_ph = PH_RTX;
    end else begin
      add_result(ACT_ACK, '0, '0, '0, last_blk[15:0]);
      if (top_len < full_bytes) begin
        next_ph = PH_IDLE;
        add_result(ACT_END, '0, '0, '0, '0);
      end else begin
        next_ph = PH_ACKED;
      end
    end
  endtask

  task automatic take_data(logic lok, logic [15:0] blk, logic [7:0] len);
    phase_e cur;
    logic   inorder;
    logic   store;
    int     b;
    int     bdist;
    int     found;
    int     cnt;
    cur   = ph;
    store = 1'b1;
    b     = int'(blk);
    if (!lok) begin
      cur_st = RS_BAD_LENGTH;
      return;
    end
    if (cur == PH_IDLE) return;
    if (cur == PH_ACKED) begin
      if (blk != 0) begin
        cur_st  = RS_AFTER_ACK;
        next_ph = PH_IDLE;
        return;
      end
      clear_window();
      next_ph = PH_XFER;
    end
    if (blk >= win_blocks) begin
      cur_st  = RS_BAD_BLOCK;
      next_ph = PH_IDLE;
      return;
    end
    good_pkt = 1'b1;
    if (b > top_blk) begin
      top_blk = b;
      top_len = len;
    end
    inorder = (cur != PH_RTX);

    // Direct write of the next block in sequence
    if (inorder && miss_total == 0) begin
      if (b == last_blk + 1) begin
        add_result(ACT_WRITE, run_off, 16'(len), '0, '0);
        last_blk = b;
        run_off  = run_off + len;
        store    = 1'b0;
      end else if (buf_base < 0) begin
        buf_base = last_blk + 1;
      end
    end

    // Reorder buffer store, with retransmit tick-off or gap recording
    if (store && buf_base >= 0) begin
      bdist = b - buf_base;
      if (bdist >= 0 && bdist < NBUF) begin
        if (!inorder) begin
          found = -1;
          for (int i = 0; i < NBUF; i++) begin
            if (found < 0 && miss_vld[i] && miss_list[i] == blk) found = i;
          end
          if (found < 0) begin
            cur_st   = RS_BAD_BLOCK;
            good_pkt = 1'b0;
            return;
          end
          miss_vld[found]  = 1'b0;
          miss_list[found] = 16'hFFFF;
          if (miss_total > 0) miss_total--;
        end
        add_result(ACT_STORE, '0, 16'(len), 4'(bdist), '0);
        if (inorder) begin
          for (int m = last_blk + 1; m < b && miss_total < NBUF; m++) begin
            miss_list[miss_total] = 16'(m);
            miss_vld[miss_total]  = 1'b1;
            miss_total++;
          end
          last_blk = b;
        end
      end
    end

    if (inorder) begin
      if (!(len < full_bytes || 17'(blk) + 17'd1 == 17'(win_blocks))) return;
    end else begin
      if (miss_total > 0) return;
      cnt = (top_blk - buf_base) * int'(full_bytes) + top_len;
      add_result(ACT_FLUSH, run_off, 16'(cnt), '0, '0);
      run_off = run_off + 32'(cnt[15:0]);
    end
    close_window();
  endtask

  // Predicts every result of one accepted item and files them as due
  task automatic receiver_step(pkt_t p);
    rcpt_t r;
    step_q.delete();
    cur_st   = RS_OK;
    good_pkt = 1'b0;
    next_ph  = ph;
    case (p.mode)
      MODE_START: begin
        if (ph == PH_IDLE) begin
          run_off  = start_off;
          idle_cnt = '0;
          clear_window();
          add_result(ACT_REQUEST, start_off, 16'(win_blocks), '0, file_no);
          next_ph = PH_XFER;
        end
      end
      MODE_DATA: take_data(p.lok, p.blk, p.len);
      MODE_ERROR: begin
        if (!p.lok) cur_st = RS_BAD_LENGTH;
        else begin
          good_pkt = 1'b1;
          next_ph  = PH_IDLE;
        end
      end
      MODE_TICK: begin
        if (ph != PH_IDLE) begin
          if (idle_cnt != 32'hFFFF_FFFF) idle_cnt++;
          if (idle_cnt >= tmo_ticks) begin
            add_result(ACT_TIMEOUT, '0, '0, '0, '0);
            next_ph = PH_IDLE;
          end
        end
      end
      default: cur_st = RS_BAD_OPCODE;
    endcase
    if (good_pkt) idle_cnt = '0;
    ph = next_ph;
    if (ph == PH_IDLE) idle_cnt = '0;
    if (step_q.size() == 0) add_result(ACT_STATUS, '0, '0, '0, '0);
    foreach (step_q[k]) begin
      r      = step_q[k];
      r.mc   = 5'(miss_total);
      r.st   = cur_st;
      r.ph   = ph;
      r.last = (k == step_q.size() - 1);
      due_results_q.push_back(r);
    end
  endtask

  // Input driver: new item or idle at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_taken) begin
        if (in_taken) void'(pkt_q.pop_front());
        if (pkt_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
          in_if.valid         <= 1'b1;
          in_if.mode          <= pkt_q[0].mode;
          in_if.length_ok     <= pkt_q[0].lok;
          in_if.block_number  <= pkt_q[0].blk;
          in_if.payload_bytes <= pkt_q[0].len;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Monitor: accepted items feed the predictor, accepted results are checked
  always @(posedge clk_i) begin
    rcpt_t e;
    pkt_t  p;
    in_taken <= in_if.valid && in_if.ready;
    if (in_if.valid && in_if.ready) begin
      p.mode = in_if.mode;
      p.lok  = in_if.length_ok;
      p.blk  = in_if.block_number;
      p.len  = in_if.payload_bytes;
      receiver_step(p);
    end
    if (out_if.valid && out_if.ready) begin
      if (due_results_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: action %0d", out_if.action);
      end else begin
        e = due_results_q.pop_front();
        if (out_if.action !== e.action || out_if.byte_offset !== e.off ||
            out_if.byte_count !== e.cnt || out_if.buffer_slot !== e.slot ||
            out_if.block_field !== e.blk || out_if.missing_count !== e.mc ||
            out_if.receive_status !== e.st || out_if.state_after !== e.ph ||
            out_if.last !== e.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp act %0d off %h cnt %0d slot %0d blk %0d mc %0d st %0d ph %0d l %b",
                     e.action, e.off, e.cnt, e.slot, e.blk, e.mc, e.st, e.ph, e.last);
            $display("         got act %0d off %h cnt %0d slot %0d blk %0d mc %0d st %0d ph %0d l %b",
                     out_if.action, out_if.byte_offset, out_if.byte_count,
                     out_if.buffer_slot, out_if.block_field, out_if.missing_count,
                     out_if.receive_status, out_if.state_after, out_if.last);
          end
        end
      end
    end
  end

  task automatic put(logic [2:0] m, logic lok, logic [15:0] b, logic [7:0] l);
    pkt_t p;
    p.mode = m;
    p.lok  = lok;
    p.blk  = b;
    p.len  = l;
    pkt_q.push_back(p);
  endtask

  task automatic put_noise();
    put(3'($urandom_range(7)), 1'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // Waits until every item is taken and every result has come
  task automatic wait_quiet();
    while (pkt_q.size() > 0 || in_if.valid || due_results_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WINDOW_BLOCKS:    win_blocks = val[7:0];
      CFG_START_OFFSET:     start_off  = val;
      CFG_FILE_NUMBER:      file_no    = val[15:0];
      CFG_FULL_BLOCK_BYTES: full_bytes = val[7:0];
      CFG_TIMEOUT_TICKS:    tmo_ticks  = val;
      default: ;
    endcase
  endtask

  task automatic set_all(logic [7:0] wb, logic [31:0] so, logic [15:0] fn, logic [7:0] fb,
                         logic [31:0] tt);
    write_reg(CFG_WINDOW_BLOCKS, {24'd0, wb});
    write_reg(CFG_START_OFFSET, so);
    write_reg(CFG_FILE_NUMBER, {16'd0, fn});
    write_reg(CFG_FULL_BLOCK_BYTES, {24'd0, fb});
    write_reg(CFG_TIMEOUT_TICKS, tt);
  endtask

  // One transfer: request, windows with gaps, retransmits, noise and ticks
  task automatic put_transfer();
    int gaps[$];
    int k;
    logic done;
    put(MODE_START, 1'($urandom), 16'($urandom), 8'($urandom));
    done = 1'b0;
    for (int w = 0; w < 3 && !done; w++) begin
      gaps.delete();
      for (int b = 0; b < win_blocks && b < 40 && !done; b++) begin
        if ($urandom_range(99) < 6) put_noise();
        if ($urandom_range(99) < 5) put(MODE_TICK, 1'($urandom), 16'($urandom), 8'($urandom));
        if (b < win_blocks - 1 && $urandom_range(99) < 25) gaps.push_back(b);
        else if ($urandom_range(99) < 8) begin
          put(MODE_DATA, 1'b1, 16'(b), 8'($urandom_range(full_bytes - 1, 0)));
          done = 1'b1;
        end else begin
          put(MODE_DATA, 1'b1, 16'(b),
              ($urandom_range(9) == 0) ? 8'($urandom_range(255, full_bytes)) : full_bytes);
        end
      end
      if (win_blocks > 40 && !done) put(MODE_DATA, 1'b1, 16'(win_blocks - 1), full_bytes);
      while (gaps.size() > 0) begin
        k = $urandom_range(gaps.size() - 1);
        if ($urandom_range(99) < 5) put(MODE_DATA, 1'b1, 16'($urandom_range(255)), full_bytes);
        put(MODE_DATA, 1'b1, 16'(gaps[k]), full_bytes);
        gaps.delete(k);
      end
    end
    if ($urandom_range(3) == 0) put(MODE_ERROR, 1'b1, 16'($urandom), 8'($urandom));
  endtask

  // Random part of one setting, stopped at about the given item count
  task automatic put_random(int n);
    int stop;
    stop = pkt_q.size() + n;
    while (pkt_q.size() < stop) begin
      if ($urandom_range(99) < 80) put_transfer();
      else put_noise();
    end
  endtask

  initial begin
    errors   = 0;
    snd_idle = 17;
    rcv_idle = 57;
    in_taken = 1'b0;
    rst_ni   = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    in_if.valid         = 1'b0;
    in_if.mode          = '0;
    in_if.length_ok     = 1'b0;
    in_if.block_number  = '0;
    in_if.payload_bytes = '0;
    out_if.ready        = 1'b0;
    win_blocks = '0;
    start_off  = '0;
    file_no    = '0;
    full_bytes = FULL_BYTES_RST;
    tmo_ticks  = TIMEOUT_RST;
    ph       = PH_IDLE;
    clear_window();
    run_off  = '0;
    idle_cnt = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: special cases in one short run
    set_all(8'd4, 32'h0000_1000, 16'h00A5, 8'd128, 32'd3);
    put(MODE_DATA, 1'b1, 16'd0, 8'd128);       // data while idle
    put(MODE_START, 1'b1, 16'd0, 8'd0);
    put(MODE_START, 1'b1, 16'd0, 8'd0);        // start while busy
    put(MODE_DATA, 1'b0, 16'd0, 8'd128);       // bad length
    put(MODE_DATA, 1'b1, 16'd0, 8'd128);
    put(MODE_DATA, 1'b1, 16'd2, 8'd128);       // gap recorded
    put(MODE_DATA, 1'b1, 16'd3, 8'd255);       // window end, retransmit list
    put(MODE_DATA, 1'b1, 16'd3, 8'd128);       // retransmit not on list
    put(MODE_DATA, 1'b1, 16'd1, 8'd128);       // tick-off, flush, ack
    put(MODE_DATA, 1'b1, 16'd2, 8'd128);       // nonzero block after ack
    put(MODE_START, 1'b1, 16'd0, 8'd0);
    put(MODE_DATA, 1'b1, 16'hFFFF, 8'd0);      // block beyond window
    put(MODE_START, 1'b1, 16'd0, 8'd0);
    put(MODE_TICK, 1'b1, 16'd0, 8'd0);
    put(MODE_TICK, 1'b1, 16'd0, 8'd0);
    put(MODE_TICK, 1'b1, 16'd0, 8'd0);         // timeout
    put(3'd4, 1'b1, 16'd0, 8'd0);
    put(3'd7, 1'b0, 16'hFFFF, 8'hFF);          // unknown opcodes
    put(MODE_ERROR, 1'b0, 16'd0, 8'd0);
    put(MODE_START, 1'b1, 16'd0, 8'd0);
    put(MODE_ERROR, 1'b1, 16'd0, 8'd0);        // error packet ends transfer
    put(MODE_START, 1'b1, 16'd0, 8'd0);
    put(MODE_DATA, 1'b1, 16'd0, 8'd5);         // short first block ends transfer
    wait_quiet();

    // Random part over several settings, extremes among them
    for (int s = 0; s < 6; s++) begin
      snd_idle = (s < 2) ? 17 : (s < 4) ? 57 : 0;
      rcv_idle = (s < 2) ? 57 : (s < 4) ? 17 : 0;
      case (s)
        0: set_all(8'd255, 32'hFFFF_FFF0, 16'hFFFF, 8'd255, 32'hFFFF_FFFF);
        1: set_all(8'd0, 32'd0, 16'd0, 8'd1, 32'd1);
        default: set_all(8'($urandom_range(20, 1)), $urandom, 16'($urandom),
                         8'($urandom_range(255, 1)), 32'($urandom_range(12, 1)));
      endcase
      if (s == 3) begin
        // sender holds off until every result is back
        put_random(30);
        wait_quiet();
        put_random(30);
      end else begin
        put_random(58);
      end
      wait_quiet();
    end

    if (errors == 0) begin
      $display("windowed_block_receiver regression: pass");
    end else begin
      $display("windowed_block_receiver regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 2_000_000);
    $display("windowed_block_receiver regression: fail");
    $finish;
  end

endmodule

// ===== windowed_block_receiver.f =====
sv/wbr_pkg.sv
sv/wbr_in_if.sv
sv/wbr_out_if.sv
sv/wbr_ctrl.sv
sv/wbr_datapath.sv
sv/windowed_block_receiver.sv
sv/wbr_checker.sv
dv/windowed_block_receiver_tb.sv
